[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on the rising clock edge, held off while reset is asserted
`define SMW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("check failed");

// check a property on every rising clock edge, reset included
`define SMW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("check failed");

`endif

[rtl/smw_pkg.sv]
// Shared constants, codes and types of the stack with middle delete.
package smw_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_DELMID = 2'd2,
    FN_QUERY  = 2'd3
  } smw_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } smw_status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_RESULT = 1'b1
  } smw_state_e;

  typedef struct packed {
    logic            en;
    smw_func_e       func;
    logic [CntW-1:0] count;
    logic [CntW-1:0] mid;
  } smw_ctl_t;

  function automatic logic [CntW-1:0] mid_pos(input logic [CntW-1:0] n);
    logic [CntW-1:0] nm1;
    nm1 = n - CntW'(1);
    return nm1 >> 1;
  endfunction

endpackage

[rtl/smw_cell.sv]
// One stack cell: holds one entry, loads a pushed value or its upper neighbor.
module smw_cell (
  input  logic                          clk_i,
  input  smw_pkg::smw_ctl_t             ctl_i,
  input  logic [smw_pkg::IdxW-1:0]      idx_i,
  input  logic signed [smw_pkg::DataW-1:0] push_value_i,
  input  logic signed [smw_pkg::DataW-1:0] upper_i,
  output logic signed [smw_pkg::DataW-1:0] value_o
);

  logic [smw_pkg::CntW-1:0]         pos;
  logic                             load_push;
  logic                             load_shift;
  logic signed [smw_pkg::DataW-1:0] value_q;
  logic signed [smw_pkg::DataW-1:0] value_d;

  assign pos = smw_pkg::CntW'(idx_i);

  assign load_push = ctl_i.en && (ctl_i.func == smw_pkg::FN_PUSH) &&
                     (ctl_i.count < smw_pkg::CntW'(smw_pkg::Depth)) &&
                     (pos == ctl_i.count);

  assign load_shift = ctl_i.en && (ctl_i.func == smw_pkg::FN_DELMID) &&
                      (ctl_i.count != '0) && (pos >= ctl_i.mid) &&
                      ((pos + smw_pkg::CntW'(1)) < ctl_i.count);

  always_comb begin
    priority if (load_push) begin
      value_d = push_value_i;
    end else if (load_shift) begin
      value_d = upper_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[rtl/stack_with_middle_delete_top.sv]
// Top level of the stack with middle delete: cell chain, count and result register.
//
//  channel | signals                                         | direction
//  in      | in_valid_i, in_stall_o, func_i, push_value_i    | request in
//  out     | out_valid_o, out_stall_i, status_o, removed_value_o,
//          | top_value_o, middle_value_o, fill_count_o       | result out
//
// For a request, the cells shift or load and the removed entry is captured
// at acceptance, then top and middle are read into the result register.
// Reset clears the count and the control, not the cells.
// While a result waits under out_stall_i, one further request is accepted
// and held in its read cycle until the result register frees.
module stack_with_middle_delete_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       func_i,
  input  logic signed [smw_pkg::DataW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [smw_pkg::DataW-1:0] removed_value_o,
  output logic signed [smw_pkg::DataW-1:0] top_value_o,
  output logic signed [smw_pkg::DataW-1:0] middle_value_o,
  output logic [smw_pkg::CntW-1:0]         fill_count_o
);

  smw_pkg::smw_state_e              state_q, state_d;
  smw_pkg::smw_ctl_t                ctl;
  smw_pkg::smw_func_e               func;
  smw_pkg::smw_status_e             status_d, status_q;
  logic [smw_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [smw_pkg::CntW-1:0]         rm_sel;
  logic [smw_pkg::CntW-1:0]         top_sel;
  logic [smw_pkg::CntW-1:0]         mid_sel;
  logic signed [smw_pkg::DataW-1:0] removed_d, removed_q;
  logic signed [smw_pkg::DataW-1:0] top_rd, mid_rd;
  logic signed [smw_pkg::DataW-1:0] cell_val [smw_pkg::Depth];
  logic                             accept;
  logic                             load_out;
  logic                             out_valid_q;
  logic [1:0]                       out_status_q;
  logic signed [smw_pkg::DataW-1:0] out_removed_q, out_top_q, out_mid_q;
  logic [smw_pkg::CntW-1:0]         out_count_q;

  assign func   = smw_pkg::smw_func_e'(func_i);
  assign accept = in_valid_i && !in_stall_o;

  assign ctl.en    = accept;
  assign ctl.func  = func;
  assign ctl.count = cnt_q;
  assign ctl.mid   = smw_pkg::mid_pos(cnt_q);

  for (genvar i = 0; i < smw_pkg::Depth; i++) begin : g_cell
    logic signed [smw_pkg::DataW-1:0] upper;
    if (i == smw_pkg::Depth - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner
      assign upper = cell_val[i+1];
    end
    smw_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .idx_i        (smw_pkg::IdxW'(i)),
      .push_value_i (push_value_i),
      .upper_i      (upper),
      .value_o      (cell_val[i])
    );
  end

  // request decode: status, removed entry, new count
  always_comb begin
    status_d = smw_pkg::ST_OK;
    cnt_d    = cnt_q;
    rm_sel   = (func == smw_pkg::FN_POP) ? (cnt_q - smw_pkg::CntW'(1))
                                         : smw_pkg::mid_pos(cnt_q);
    unique case (func)
      smw_pkg::FN_PUSH: begin
        if (cnt_q >= smw_pkg::CntW'(smw_pkg::Depth)) begin
          status_d = smw_pkg::ST_FULL;
        end else begin
          cnt_d = cnt_q + smw_pkg::CntW'(1);
        end
      end
      smw_pkg::FN_POP, smw_pkg::FN_DELMID: begin
        if (cnt_q == '0) begin
          status_d = smw_pkg::ST_EMPTY;
        end else begin
          cnt_d = cnt_q - smw_pkg::CntW'(1);
        end
      end
      smw_pkg::FN_QUERY: begin
        cnt_d = cnt_q;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign top_sel = cnt_q - smw_pkg::CntW'(1);
  assign mid_sel = smw_pkg::mid_pos(cnt_q);

  always_comb begin
    removed_d = '0;
    top_rd    = '0;
    mid_rd    = '0;
    for (int i = 0; i < smw_pkg::Depth; i++) begin
      if (smw_pkg::CntW'(i) == rm_sel) begin
        removed_d = removed_d | cell_val[i];
      end
      if (smw_pkg::CntW'(i) == top_sel) begin
        top_rd = top_rd | cell_val[i];
      end
      if (smw_pkg::CntW'(i) == mid_sel) begin
        mid_rd = mid_rd | cell_val[i];
      end
    end
    if ((status_d != smw_pkg::ST_OK) ||
        ((func != smw_pkg::FN_POP) && (func != smw_pkg::FN_DELMID))) begin
      removed_d = '0;
    end
    if (cnt_q == '0) begin
      top_rd = '0;
      mid_rd = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = smw_pkg::S_RESULT;
        end
      end
      smw_pkg::S_RESULT: begin
        if (load_out) begin
          state_d = smw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = smw_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      smw_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
      end
      smw_pkg::S_RESULT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smw_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
    if (load_out) begin
      out_status_q  <= status_q;
      out_removed_q <= removed_q;
      out_top_q     <= top_rd;
      out_mid_q     <= mid_rd;
      out_count_q   <= cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign top_value_o     = out_top_q;
  assign middle_value_o  = out_mid_q;
  assign fill_count_o    = out_count_q;

endmodule

[rtl/smw_checker.sv]
// Port-level checks of the stack with middle delete, bound to the top level.
`include "assert_macros.svh"

module smw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [1:0]                       func_i,
  input logic signed [smw_pkg::DataW-1:0] push_value_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [1:0]                       status_o,
  input logic signed [smw_pkg::DataW-1:0] removed_value_o,
  input logic signed [smw_pkg::DataW-1:0] top_value_o,
  input logic signed [smw_pkg::DataW-1:0] middle_value_o,
  input logic [smw_pkg::CntW-1:0]         fill_count_o
);

  `SMW_ASSERT(a_in_hold, clk_i, rst_ni,
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(func_i) && $stable(push_value_i)))
  `SMW_ASSERT(a_count_bound, clk_i, rst_ni,
    out_valid_o |-> (fill_count_o <= smw_pkg::CntW'(smw_pkg::Depth)))
  `SMW_ASSERT(a_empty_zero, clk_i, rst_ni,
    (out_valid_o && (fill_count_o == '0)) |-> ((top_value_o == '0) && (middle_value_o == '0)))
  `SMW_ASSERT(a_full_refused, clk_i, rst_ni,
    (out_valid_o && (status_o == smw_pkg::ST_FULL)) |->
      ((fill_count_o == smw_pkg::CntW'(smw_pkg::Depth)) && (removed_value_o == '0)))
  `SMW_ASSERT(a_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(removed_value_o) &&
       $stable(top_value_o) && $stable(middle_value_o) && $stable(fill_count_o)))

endmodule

bind stack_with_middle_delete_top smw_checker u_smw_checker (.*);
